@@ rtl/retransmit_timer_queue_core_defines.svh @@
// Assertion macros shared by the retransmit timer queue RTL.
`ifndef RETRANSMIT_TIMER_QUEUE_CORE_DEFINES_SVH
`define RETRANSMIT_TIMER_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define RTTQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define RTTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/rttq_pkg.sv @@
// Types and constants of the retransmit timer queue.
package rttq_pkg;

	localparam int SEQ_W      = 31;
	localparam int TIME_W     = 32;
	localparam int TMO_W      = 16;
	localparam int MOD_W      = 32;
	localparam int CNT_OUT_W  = 9;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 1;
	localparam int STEP_W     = $clog2(SEQ_W);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 1'd1;

	// Register reset values and modulus limits.
	localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd30;
	localparam logic [MOD_W-1:0] MODULUS_RESET = 32'd65536;
	localparam logic [MOD_W-1:0] MODULUS_MIN   = 32'd2;
	localparam logic [MOD_W-1:0] MODULUS_MAX   = 32'h8000_0000;

	// Operation codes.
	localparam logic [1:0] OP_SEND  = 2'd0;
	localparam logic [1:0] OP_ACK   = 2'd1;
	localparam logic [1:0] OP_CHECK = 2'd2;
	localparam logic [1:0] OP_FLUSH = 2'd3;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [TIME_W-1:0] now_ms;
		logic [SEQ_W-1:0]  ack_due;
		logic [SEQ_W-1:0]  ack_num;
		logic [SEQ_W-1:0]  next_seq;
		logic [SEQ_W-1:0]  unacked_bytes;
	} in_item_t;

	typedef struct packed {
		logic                 expired;
		logic [SEQ_W-1:0]     rewound_seq;
		logic [CNT_OUT_W-1:0] pending_count;
		logic                 status;
	} out_item_t;

	typedef struct packed {
		logic [TIME_W-1:0] send_time;
		logic [SEQ_W-1:0]  exp_ack;
	} ring_entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_ACK_LOAD,
		ST_ACK_MOD,
		ST_ACK_WAIT,
		ST_CHK_MOD,
		ST_FINISH
	} ctrl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_item;
		logic push;
		logic pop;
		logic flush;
		logic rem_start;
		logic rem_sel_check;
		logic set_status;
		logic set_expired;
		logic out_load;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] opcode;
		logic       full;
		logic       empty;
		logic       timed_out;
		logic       rem_done;
		logic       not_after;
		logic       out_free;
	} dp_status_t;

endpackage

@@ rtl/rttq_chan_if.sv @@
// Valid/ready channel interface carrying one payload item per transfer.
interface rttq_chan_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/retransmit_timer_queue_core.sv @@
// Each item passes the idle state (accept), the dispatch state, its operation's own states and
// the finish state, which loads the result register once the output register is free. An
// expiring check and each ack test use the bit-serial remainder unit; an ack tests and pops
// head entries until one is kept or the ring is empty.
// One item at a time: a new item is taken only in the idle state, after the previous result is
// loaded. Reset (arst_n low) empties the ring, timeout 30 ms, modulus 65536.
module retransmit_timer_queue_core import rttq_pkg::*; #(
	parameter int RING_DEPTH = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	rttq_chan_if.sink             ingress,
	rttq_chan_if.source           egress
);

	dp_cmd_t    cmd;
	dp_status_t stat;
	logic       in_ready;

	assign ingress.ready = in_ready;

	// Sequencer.
	rttq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (ingress.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Ring, arithmetic and result register.
	rttq_dp #(
		.RING_DEPTH (RING_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_item   (ingress.payload),
		.cmd       (cmd),
		.stat      (stat),
		.egress    (egress)
	);

endmodule

@@ rtl/rttq_rem.sv @@
// Bit-serial remainder unit: magnitude of a sequence difference modulo the sequence space.
module rttq_rem import rttq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SEQ_W-1:0] dividend,
	input  logic [MOD_W-1:0] divisor,
	output logic             done,
	output logic [SEQ_W-1:0] remainder
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [SEQ_W-1:0]  dvd_q;
	logic [MOD_W-1:0]  div_q;
	logic [MOD_W-1:0]  rem_q;
	logic [MOD_W-1:0]  trial;
	logic              fits;

	// Shift in the next dividend bit; the partial remainder stays below the divisor.
	assign trial = {rem_q[MOD_W-2:0], dvd_q[SEQ_W-1]};
	assign fits  = ({1'b0, dividend} < divisor);

	// Control: a dividend already below the divisor finishes at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= !fits;
				done_q <= fits;
				step_q <= STEP_W'(SEQ_W - 1);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Restoring remainder, one bit per cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= fits ? {1'b0, dividend} : '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[SEQ_W-2:0], 1'b0};
			rem_q <= (trial >= div_q) ? (trial - div_q) : trial;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q[SEQ_W-1:0];

endmodule

@@ rtl/rttq_dp.sv @@
// Datapath: timer ring memory, ring pointers, configuration, modular arithmetic, result register.
`include "retransmit_timer_queue_core_defines.svh"

module rttq_dp import rttq_pkg::*; #(
	parameter int RING_DEPTH = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  in_item_t              in_item,
	input  dp_cmd_t               cmd,
	output dp_status_t            stat,
	rttq_chan_if.source           egress
);

	localparam int IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int CW = $clog2(RING_DEPTH + 1);

	logic [TMO_W-1:0]  timeout_q;
	logic [MOD_W-1:0]  mod_q;
	in_item_t          item_q;
	logic [IW-1:0]     head_q;
	logic [CW-1:0]     count_q;
	ring_entry_t       mem [RING_DEPTH];
	ring_entry_t       rd_q;
	logic [IW:0]       wr_sum;
	logic [IW-1:0]     wr_idx;
	logic [IW-1:0]     head_next;
	logic              full;
	logic              empty;
	logic [TIME_W-1:0] age;
	logic [SEQ_W-1:0]  op_a;
	logic [SEQ_W-1:0]  op_b;
	logic [SEQ_W:0]    diff;
	logic [SEQ_W-1:0]  diff_mag;
	logic              neg_q;
	logic              rem_done;
	logic [SEQ_W-1:0]  rem_val;
	logic [MOD_W-1:0]  fix;
	logic              res_expired_q;
	logic [SEQ_W-1:0]  res_rewound_q;
	logic              res_status_q;
	logic              out_valid_q;
	out_item_t         out_q;
	logic              out_free;

	// Configuration registers; the modulus is clamped to its legal range on write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
			mod_q     <= MODULUS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TIMEOUT: timeout_q <= cfg_data[TMO_W-1:0];
				CFG_MODULUS: begin
					if (cfg_data < MODULUS_MIN) begin
						mod_q <= MODULUS_MIN;
					end else if (cfg_data > MODULUS_MAX) begin
						mod_q <= MODULUS_MAX;
					end else begin
						mod_q <= cfg_data;
					end
				end
				default: ;
			endcase
		end
	end

	// Captured input item.
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= in_item;
		end
	end

	// Ring pointers.
	assign full      = (count_q == CW'(RING_DEPTH));
	assign empty     = (count_q == '0);
	assign wr_sum    = {1'b0, head_q} + {1'b0, count_q[IW-1:0]};
	assign wr_idx    = (wr_sum >= (IW+1)'(RING_DEPTH)) ? IW'(wr_sum - (IW+1)'(RING_DEPTH))
	                                                   : wr_sum[IW-1:0];
	assign head_next = (head_q == IW'(RING_DEPTH - 1)) ? '0 : head_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (cmd.flush) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (cmd.push) begin
			count_q <= count_q + 1'b1;
		end else if (cmd.pop) begin
			head_q  <= head_next;
			count_q <= count_q - 1'b1;
		end
	end

	// Ring memory: write at the tail, registered read of the head entry.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[wr_idx] <= '{send_time: item_q.now_ms, exp_ack: item_q.ack_due};
		end
		rd_q <= mem[head_q];
	end

	// Age of the oldest entry against the timeout.
	assign age = item_q.now_ms - rd_q.send_time;

	// Signed difference of the two sequence operands, reduced by the remainder unit.
	assign op_a     = cmd.rem_sel_check ? item_q.next_seq : rd_q.exp_ack;
	assign op_b     = cmd.rem_sel_check ? item_q.unacked_bytes : item_q.ack_num;
	assign diff     = {1'b0, op_a} - {1'b0, op_b};
	assign diff_mag = diff[SEQ_W] ? SEQ_W'(-diff) : diff[SEQ_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.rem_start) begin
			neg_q <= diff[SEQ_W];
		end
	end

	rttq_rem u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.rem_start),
		.dividend  (diff_mag),
		.divisor   (mod_q),
		.done      (rem_done),
		.remainder (rem_val)
	);

	// A negative difference folds back into the sequence space.
	assign fix = (neg_q && rem_val != '0) ? (mod_q - {1'b0, rem_val}) : {1'b0, rem_val};

	// Result fields gathered while the item is worked on.
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			res_expired_q <= 1'b0;
			res_status_q  <= 1'b0;
			res_rewound_q <= in_item.next_seq;
		end else begin
			if (cmd.set_status) begin
				res_status_q <= 1'b1;
			end
			if (cmd.set_expired) begin
				res_expired_q <= 1'b1;
				res_rewound_q <= fix[SEQ_W-1:0];
			end
		end
	end

	// Output register: takes a new result when it is empty or while the old one is being transferred.
	assign out_free = !out_valid_q || egress.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (egress.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q <= '{expired: res_expired_q, rewound_seq: res_rewound_q,
			           pending_count: CNT_OUT_W'(count_q), status: res_status_q};
		end
	end

	assign egress.valid   = out_valid_q;
	assign egress.payload = out_q;

	// Status to the controller.
	assign stat.opcode    = item_q.opcode;
	assign stat.full      = full;
	assign stat.empty     = empty;
	assign stat.timed_out = (age > {{(TIME_W-TMO_W){1'b0}}, timeout_q});
	assign stat.rem_done  = rem_done;
	assign stat.not_after = !((fix != '0) && (fix < (mod_q >> 1)));
	assign stat.out_free  = out_free;

	`RTTQ_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(RING_DEPTH), "ring count above depth")
	`RTTQ_ASSERT_NOW(a_push_room, clk, arst_n, cmd.push, !full, "push into a full ring")
	`RTTQ_ASSERT_NEXT(a_pop_count, clk, arst_n, cmd.pop, count_q == $past(count_q) - 1'b1, "pop did not drop the count by one")
	`RTTQ_ASSERT_NOW(a_out_free, clk, arst_n, cmd.out_load, out_free, "result loaded over an untransferred result")

endmodule

@@ rtl/rttq_ctrl.sv @@
// Controller: sequences each operation over the datapath.
`include "retransmit_timer_queue_core_defines.svh"

module rttq_ctrl import rttq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t stat,
	output dp_cmd_t    cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				unique case (stat.opcode)
					OP_SEND: begin
						if (stat.full) begin
							cmd.set_status = 1'b1;
						end else begin
							cmd.push = 1'b1;
						end
						state_d = ST_FINISH;
					end
					OP_ACK: state_d = ST_ACK_LOAD;
					OP_CHECK: begin
						if (!stat.empty && stat.timed_out) begin
							cmd.rem_start     = 1'b1;
							cmd.rem_sel_check = 1'b1;
							state_d           = ST_CHK_MOD;
						end else begin
							state_d = ST_FINISH;
						end
					end
					OP_FLUSH: begin
						cmd.flush = 1'b1;
						state_d   = ST_FINISH;
					end
					default: state_d = ST_FINISH;
				endcase
			end
			// Test the head entry against the received ack.
			ST_ACK_LOAD: begin
				if (stat.empty) begin
					state_d = ST_FINISH;
				end else begin
					cmd.rem_start = 1'b1;
					state_d       = ST_ACK_MOD;
				end
			end
			ST_ACK_MOD: begin
				if (stat.rem_done) begin
					if (stat.not_after) begin
						cmd.pop = 1'b1;
						state_d = ST_ACK_WAIT;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			// Wait state so the memory can read the new head.
			ST_ACK_WAIT: state_d = ST_ACK_LOAD;
			ST_CHK_MOD: begin
				cmd.rem_sel_check = 1'b1;
				if (stat.rem_done) begin
					cmd.set_expired = 1'b1;
					cmd.flush       = 1'b1;
					state_d         = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`RTTQ_ASSERT_NOW(a_one_ring_op, clk, arst_n, 1'b1, $countones({cmd.push, cmd.pop, cmd.set_status}) <= 1, "conflicting ring commands")
	`RTTQ_ASSERT_NEXT(a_accept_dispatch, clk, arst_n, cmd.load_item, state_q == ST_DISPATCH, "accepted item not dispatched")
	`RTTQ_ASSERT_NOW(a_expire_check, clk, arst_n, cmd.set_expired, cmd.flush && cmd.rem_sel_check, "expiry without flush")

endmodule
